### src/hid_keyboard_event_queue_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard event queue.
// Each macro checks a property on the rising clock edge, outside of reset.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_EVENT_QUEUE_TOP_MACROS_SVH
`define HID_KEYBOARD_EVENT_QUEUE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HKQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyboard event queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define HKQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyboard event queue check failed");

`endif

### src/hkq_pkg.sv
// ----------------------------------------------------------------------------
// hkq_pkg
// Types, codes and the key code decoder of the keyboard event queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hkq_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int SLOT_W    = 3;
    localparam int CODE_W    = 8;
    localparam int KIND_W    = 4;
    localparam int CHAR_W    = 7;
    localparam int EVENT_W   = KIND_W + CHAR_W;

    typedef enum logic [1:0] {
        MODE_REPORT = 2'd0,
        MODE_POLL   = 2'd1,
        MODE_ATTACH = 2'd2,
        MODE_DETACH = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR      = 4'd0,
        KIND_ENTER     = 4'd1,
        KIND_ESC       = 4'd2,
        KIND_BACKSPACE = 4'd3,
        KIND_UP        = 4'd4,
        KIND_DOWN      = 4'd5,
        KIND_LEFT      = 4'd6,
        KIND_RIGHT     = 4'd7,
        KIND_TAB       = 4'd8,
        KIND_SHIFT_TAB = 4'd9
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POLL,
        ST_RESP
    } state_t;

    // Shift bits of the modifier byte: left shift and right shift.
    localparam logic [CODE_W-1:0] SHIFT_MASK = 8'h22;

    // Shifted symbols of the digit keys 1 through 9.
    localparam logic [CHAR_W-1:0] DIGIT_SHIFT [0:8] = '{
        7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28
    };

    typedef struct packed {
        logic [1:0]        mode;
        logic [CODE_W-1:0] modifier_bits;
        logic [CODE_W-1:0] key_code_a;
        logic [CODE_W-1:0] key_code_b;
        logic [CODE_W-1:0] key_code_c;
        logic [CODE_W-1:0] key_code_d;
        logic [CODE_W-1:0] key_code_e;
        logic [CODE_W-1:0] key_code_f;
    } in_item_t;

    typedef struct packed {
        logic              event_valid;
        logic [KIND_W-1:0] event_kind;
        logic [CHAR_W-1:0] event_char;
        logic              keyboard_present;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic scan_step;
        logic read_mem;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic new_report;
        logic new_poll;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
    } decode_t;

    // Maps one usage code to an event. hit is low for codes that make no event.
    function automatic decode_t decode_key(logic [CODE_W-1:0] code, logic shift);
        decode_t           d;
        logic [CODE_W-1:0] t;
        d.hit  = 1'b1;
        d.kind = KIND_CHAR;
        d.ch   = '0;
        t      = '0;
        case (code)
            8'h28, 8'h58: d.kind = KIND_ENTER;
            8'h29:        d.kind = KIND_ESC;
            8'h2A:        d.kind = KIND_BACKSPACE;
            8'h52:        d.kind = KIND_UP;
            8'h51:        d.kind = KIND_DOWN;
            8'h50:        d.kind = KIND_LEFT;
            8'h4F:        d.kind = KIND_RIGHT;
            8'h2B:        d.kind = shift ? KIND_SHIFT_TAB : KIND_TAB;
            8'h27:        d.ch = shift ? 7'h29 : 7'h30;
            8'h55:        d.ch = 7'h2A;
            8'h57:
            begin
                // Keypad add gives an asterisk only with shift held.
                d.ch  = 7'h2A;
                d.hit = shift;
            end
            8'h2D:        d.ch = shift ? 7'h5F : 7'h2D;
            8'h2E:        d.ch = shift ? 7'h2B : 7'h3D;
            8'h37, 8'h63: d.ch = 7'h2E;
            default:
            begin
                if (code inside {[8'h04:8'h1D]})
                begin
                    t    = code + (shift ? 8'h3D : 8'h5D);
                    d.ch = t[CHAR_W-1:0];
                end
                else if (code inside {[8'h1E:8'h26]})
                begin
                    t    = code - 8'h1E;
                    d.ch = shift ? DIGIT_SHIFT[t[3:0]] : (7'h31 + t[CHAR_W-1:0]);
                end
                else
                begin
                    d.hit = 1'b0;
                end
            end
        endcase
        return d;
    endfunction

endpackage

### src/hkq_ctrl.sv
// ----------------------------------------------------------------------------
// hkq_ctrl
// Sequencer for one request: accept, report scan or poll read, then result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hkq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  hkq_pkg::ctrl_sts_t sts,
    output hkq_pkg::ctrl_cmd_t cmd
);

    hkq_pkg::state_t state_reg;
    hkq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hkq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            hkq_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (sts.new_report)
                    begin
                        state_next = hkq_pkg::ST_SCAN;
                    end
                    else if (sts.new_poll)
                    begin
                        state_next = hkq_pkg::ST_POLL;
                    end
                    else
                    begin
                        state_next = hkq_pkg::ST_RESP;
                    end
                end
            end
            hkq_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = hkq_pkg::ST_RESP;
                end
            end
            hkq_pkg::ST_POLL:
            begin
                cmd.read_mem = 1'b1;
                state_next   = hkq_pkg::ST_RESP;
            end
            hkq_pkg::ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = hkq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hkq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### src/hkq_datapath.sv
// ----------------------------------------------------------------------------
// hkq_datapath
// Held keys, slot scan and decode, event ring memory and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hid_keyboard_event_queue_top_macros.svh"

module hkq_datapath #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hkq_pkg::in_item_t  item,
    input  hkq_pkg::ctrl_cmd_t cmd,
    output hkq_pkg::ctrl_sts_t sts,
    output logic               result_valid,
    input  logic               result_stall,
    output hkq_pkg::out_item_t result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [hkq_pkg::CODE_W-1:0]  keys_reg [hkq_pkg::NUM_SLOTS];
    logic [hkq_pkg::CODE_W-1:0]  prev_reg [hkq_pkg::NUM_SLOTS];
    logic [hkq_pkg::EVENT_W-1:0] mem_array [QUEUE_DEPTH];
    logic [hkq_pkg::EVENT_W-1:0] rd_data_reg;
    logic [hkq_pkg::SLOT_W-1:0]  slot_reg;
    logic [PTR_W-1:0]            wp_reg;
    logic [PTR_W-1:0]            rp_reg;
    logic [PTR_W-1:0]            wp_inc;
    logic [PTR_W-1:0]            rp_inc;
    logic [1:0]                  mode_reg;
    logic                        shift_reg;
    logic                        connected_reg;
    logic                        poll_hit_reg;
    logic                        out_valid_reg;
    hkq_pkg::out_item_t          out_reg;
    hkq_pkg::out_item_t          out_next;
    hkq_pkg::decode_t            dec;
    logic [hkq_pkg::CODE_W-1:0]  cur_code;
    logic                        held;
    logic                        full;
    logic                        empty;
    logic                        wr_en;
    logic                        rd_hit;
    logic [hkq_pkg::KIND_W-1:0]  rd_kind;

    assign wp_inc = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
    assign full   = (wp_inc == rp_reg);
    assign empty  = (wp_reg == rp_reg);

    // Slot under scan, its held-before check and its event.
    always_comb
    begin
        case (slot_reg)
            3'd0:    cur_code = keys_reg[0];
            3'd1:    cur_code = keys_reg[1];
            3'd2:    cur_code = keys_reg[2];
            3'd3:    cur_code = keys_reg[3];
            3'd4:    cur_code = keys_reg[4];
            3'd5:    cur_code = keys_reg[5];
            default: cur_code = '0;
        endcase
        held = 1'b0;
        for (int i = 0; i < hkq_pkg::NUM_SLOTS; i++)
        begin
            if (prev_reg[i] == cur_code)
            begin
                held = 1'b1;
            end
        end
    end

    assign dec    = hkq_pkg::decode_key(cur_code, shift_reg);
    assign wr_en  = cmd.scan_step && (cur_code != '0) && !held && dec.hit && !full;
    assign rd_hit = cmd.read_mem && !empty;

    assign sts.new_report = (item.mode == hkq_pkg::MODE_REPORT);
    assign sts.new_poll   = (item.mode == hkq_pkg::MODE_POLL);
    assign sts.scan_last  = (slot_reg == 3'(hkq_pkg::NUM_SLOTS - 1));
    assign sts.out_free   = !out_valid_reg || !result_stall;

    // Request payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            mode_reg    <= item.mode;
            shift_reg   <= |(item.modifier_bits & hkq_pkg::SHIFT_MASK);
            keys_reg[0] <= item.key_code_a;
            keys_reg[1] <= item.key_code_b;
            keys_reg[2] <= item.key_code_c;
            keys_reg[3] <= item.key_code_d;
            keys_reg[4] <= item.key_code_e;
            keys_reg[5] <= item.key_code_f;
        end
    end

    // Control state: slot counter, pointers, held keys and connected flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            connected_reg <= 1'b0;
            poll_hit_reg  <= 1'b0;
            for (int i = 0; i < hkq_pkg::NUM_SLOTS; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load_item)
            begin
                slot_reg <= '0;
                // A poll leaves the connected flag as it is.
                if (item.mode == hkq_pkg::MODE_DETACH)
                begin
                    connected_reg <= 1'b0;
                    for (int i = 0; i < hkq_pkg::NUM_SLOTS; i++)
                    begin
                        prev_reg[i] <= '0;
                    end
                end
                else if (item.mode != hkq_pkg::MODE_POLL)
                begin
                    connected_reg <= 1'b1;
                end
            end
            if (cmd.scan_step)
            begin
                slot_reg <= slot_reg + 1'b1;
                if (sts.scan_last)
                begin
                    prev_reg <= keys_reg;
                end
            end
            if (wr_en)
            begin
                wp_reg <= wp_inc;
            end
            if (cmd.read_mem)
            begin
                poll_hit_reg <= !empty;
            end
            if (rd_hit)
            begin
                rp_reg <= rp_inc;
            end
        end
    end

    // Event ring memory, one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wp_reg] <= {dec.ch, dec.kind};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_mem)
        begin
            rd_data_reg <= mem_array[rp_reg];
        end
    end

    assign rd_kind = rd_data_reg[hkq_pkg::KIND_W-1:0];

    always_comb
    begin
        out_next                  = '0;
        out_next.keyboard_present = connected_reg;
        if ((mode_reg == hkq_pkg::MODE_POLL) && poll_hit_reg)
        begin
            out_next.event_valid = 1'b1;
            out_next.event_kind  = rd_kind;
            if (rd_kind == hkq_pkg::KIND_CHAR)
            begin
                out_next.event_char = rd_data_reg[hkq_pkg::EVENT_W-1:hkq_pkg::KIND_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `HKQ_ASSERT_SAME(a_no_write_when_full, wr_en, !full)
    `HKQ_ASSERT_SAME(a_scan_in_range, cmd.scan_step, slot_reg <= 3'(hkq_pkg::NUM_SLOTS - 1))
    `HKQ_ASSERT_NEXT(a_read_moves_pointer, rd_hit, rp_reg != $past(rp_reg))
    `HKQ_ASSERT_SAME(a_load_only_when_free, cmd.load_out, !out_valid_reg || !result_stall)

endmodule

### src/hid_keyboard_event_queue_top.sv
// A keyboard report passes through accept, six slot scan steps through the shared
// decoder, and result; a poll passes through accept, event memory read and result;
// attach and detach pass through accept and result. The sequencer takes one request
// at a time, and a new one waits until the previous request has left the result
// state. Reset is asynchronous, active low, and empties the queue, clears the held
// keys and the connected flag; the event memory itself is not cleared.
// ----------------------------------------------------------------------------
// hid_keyboard_event_queue_top
// Boot keyboard report decoder that turns new key presses into queued events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_keyboard_event_queue_top #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  hkq_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output hkq_pkg::out_item_t result
);

    // The controller and the datapath talk only through these two groups.
    // The command group tells the datapath when to take a request, when to
    // step the slot scan, when to read the event memory and when to load the
    // result register. The status group reports the kind of the incoming
    // request, the last slot of the scan and whether the result register can
    // take a new result.
    hkq_pkg::ctrl_cmd_t cmd;
    hkq_pkg::ctrl_sts_t sts;

    // The sequencer holds one request at a time. A finished result sits in
    // the output register, so a new request can be taken while the previous
    // result still waits for the downstream side.
    hkq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // The datapath scans one report slot per cycle: it checks the code against
    // the keys held in the previous report, decodes it and, when the ring has
    // room, writes the event. One slot of the ring always stays empty, so a
    // full ring drops new events. Polls read the oldest event through the
    // registered read port of the event memory.
    hkq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### bench/tb_hid_keyboard_event_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard event queue testbench
// Sends boot keyboard reports, polls, attaches and detaches to the block. A
// behavioral model of the key decoder and the event ring predicts every
// result, and each result is compared field by field as it leaves the block.
// Both sides idle and stall at random, and one long receiver hold fills the
// block up.
// ----------------------------------------------------------------------------

module tb_hid_keyboard_event_queue_top;

    import hkq_pkg::*;

    localparam int QUEUE_DEPTH  = 32;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_CYCLES = 16;

    // The one-slot-empty ring holds at most this many events.
    localparam int EVENT_ROOM = QUEUE_DEPTH - 1;

    // Characters of the digit keys 1 through 9, plain and with shift.
    localparam logic [8*9-1:0] DIGIT_PLAIN   = "123456789";
    localparam logic [8*9-1:0] DIGIT_SHIFTED = "!@#$%^&*(";
    localparam logic [7:0]     CASE_OFFSET   = "a" - "A";

    // Usage codes with a fixed meaning outside the letter and digit ranges.
    localparam int               NAMED_COUNT = 15;
    localparam logic [8*15-1:0]  NAMED_KEY_CODES = {
        8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h37, 8'h4F,
        8'h50, 8'h51, 8'h52, 8'h55, 8'h57, 8'h58, 8'h63
    };

    // One decoded key press, as the event ring stores it.
    typedef struct packed {
        logic              hit;
        kind_t             kind;
        logic [CHAR_W-1:0] ch;
    } key_press_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_stall;
    in_item_t   item         = '0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    out_item_t  result;

    // Model state of the block.
    logic [CODE_W-1:0] held_keys [NUM_SLOTS];
    key_press_t        queued_keys [$];
    logic              link_up;

    // Results predicted for accepted requests, oldest first.
    out_item_t awaited_results [$];

    int  failures      = 0;
    int  cycle_count   = 0;
    int  burst_left    = 0;
    bit  pace_on       = 1'b1;
    int  hold_requests = 0;
    int  hold_seen     = 0;
    int  hold_left     = 0;

    hid_keyboard_event_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_hid_keyboard_event_queue_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------

    // Turns one usage code into an event. hit is low for codes with no event.
    function automatic key_press_t decode_press(logic [CODE_W-1:0] code, logic shifted);
        key_press_t press;
        logic [7:0] ascii;
        int         digit;
        press.hit  = 1'b1;
        press.kind = KIND_CHAR;
        ascii      = 8'h00;
        digit      = 0;
        case (code)
            8'h28, 8'h58: press.kind = KIND_ENTER;
            8'h29:        press.kind = KIND_ESC;
            8'h2A:        press.kind = KIND_BACKSPACE;
            8'h52:        press.kind = KIND_UP;
            8'h51:        press.kind = KIND_DOWN;
            8'h50:        press.kind = KIND_LEFT;
            8'h4F:        press.kind = KIND_RIGHT;
            8'h2B:        press.kind = shifted ? KIND_SHIFT_TAB : KIND_TAB;
            8'h27:        ascii = shifted ? ")" : "0";
            8'h55:        ascii = "*";
            8'h2D:        ascii = shifted ? "_" : "-";
            8'h2E:        ascii = shifted ? "+" : "=";
            8'h37, 8'h63: ascii = ".";
            8'h57:
            begin
                // Keypad add only makes an event with shift, and then it is '*'.
                ascii     = "*";
                press.hit = shifted;
            end
            default:
            begin
                if (code >= 8'h04 && code <= 8'h1D)
                begin
                    ascii = "a" + (code - 8'h04);
                    if (shifted)
                    begin
                        ascii = ascii - CASE_OFFSET;
                    end
                end
                else if (code >= 8'h1E && code <= 8'h26)
                begin
                    digit = int'(code - 8'h1E);
                    ascii = shifted ? DIGIT_SHIFTED[8*(8-digit) +: 8]
                                    : DIGIT_PLAIN[8*(8-digit) +: 8];
                end
                else
                begin
                    press.hit = 1'b0;
                end
            end
        endcase
        press.ch = ascii[CHAR_W-1:0];
        return press;
    endfunction

    // Applies one accepted request to the model and queues its result.
    task automatic predict_request(input in_item_t req);
        out_item_t         outcome;
        logic [CODE_W-1:0] codes [NUM_SLOTS];
        key_press_t        press;
        logic              shifted;
        bit                held;
        outcome = '0;
        case (mode_t'(req.mode))
            MODE_REPORT:
            begin
                link_up = 1'b1;
                shifted = (req.modifier_bits & SHIFT_MASK) != '0;
                codes   = '{req.key_code_a, req.key_code_b, req.key_code_c,
                            req.key_code_d, req.key_code_e, req.key_code_f};
                // New presses are taken in slot order; a full ring drops them.
                foreach (codes[i])
                begin
                    held = 1'b0;
                    foreach (held_keys[j])
                    begin
                        if (held_keys[j] == codes[i])
                        begin
                            held = 1'b1;
                        end
                    end
                    if (codes[i] != '0 && !held)
                    begin
                        press = decode_press(codes[i], shifted);
                        if (press.hit && queued_keys.size() < EVENT_ROOM)
                        begin
                            queued_keys.push_back(press);
                        end
                    end
                end
                held_keys = codes;
            end
            MODE_POLL:
            begin
                if (queued_keys.size() != 0)
                begin
                    press              = queued_keys.pop_front();
                    outcome.event_valid = 1'b1;
                    outcome.event_kind  = press.kind;
                    outcome.event_char  = (press.kind == KIND_CHAR) ? press.ch : '0;
                end
            end
            MODE_ATTACH:
            begin
                link_up = 1'b1;
            end
            MODE_DETACH:
            begin
                // Detach forgets the held keys but keeps queued events.
                link_up   = 1'b0;
                held_keys = '{default: '0};
            end
        endcase
        outcome.keyboard_present = link_up;
        awaited_results.push_back(outcome);
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    function automatic in_item_t make_request(
        mode_t             mode,
        logic [CODE_W-1:0] mods,
        logic [CODE_W-1:0] a,
        logic [CODE_W-1:0] b,
        logic [CODE_W-1:0] c,
        logic [CODE_W-1:0] d,
        logic [CODE_W-1:0] e,
        logic [CODE_W-1:0] f
    );
        in_item_t req;
        req.mode          = mode;
        req.modifier_bits = mods;
        req.key_code_a    = a;
        req.key_code_b    = b;
        req.key_code_c    = c;
        req.key_code_d    = d;
        req.key_code_e    = e;
        req.key_code_f    = f;
        return req;
    endfunction

    // A poll, attach or detach request; the key fields carry random junk,
    // which the block must ignore.
    function automatic in_item_t plain_request(mode_t mode);
        return make_request(mode, 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Mostly letters and digits, then named keys, empty slots and noise.
    function automatic logic [CODE_W-1:0] pick_key_code();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            return 8'($urandom_range(8'h04, 8'h27));
        end
        else if (pick < 75)
        begin
            return NAMED_KEY_CODES[8*$urandom_range(0, NAMED_COUNT-1) +: 8];
        end
        else if (pick < 88)
        begin
            return 8'h00;
        end
        return 8'($urandom);
    endfunction

    // A report that looks like typing: some keys stay held, others change.
    function automatic in_item_t typing_report();
        logic [CODE_W-1:0] keys [NUM_SLOTS];
        logic [CODE_W-1:0] mods;
        foreach (keys[i])
        begin
            keys[i] = ($urandom_range(0, 2) == 0) ? held_keys[i] : pick_key_code();
        end
        case ($urandom_range(0, 3))
            0:       mods = 8'h00;
            1:       mods = 8'h02;
            2:       mods = 8'h20;
            default: mods = 8'($urandom);
        endcase
        return make_request(MODE_REPORT, mods, keys[0], keys[1], keys[2],
                            keys[3], keys[4], keys[5]);
    endfunction

    // Offers one request and returns at the edge that accepts it. Between
    // bursts the valid line drops for a random number of cycles; it is never
    // dropped and raised in the same time step.
    task automatic send_request(input in_item_t req);
        int gap;
        if (pace_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        item       <= req;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        predict_request(req);
    endtask

    // Lowers valid and waits until every predicted result has come back.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic poll_until_empty();
        while (queued_keys.size() != 0)
        begin
            send_request(plain_request(MODE_POLL));
        end
        // One more poll sees the empty ring.
        send_request(plain_request(MODE_POLL));
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // The receiver takes four stall habits in turn: no stalls, light
    // random stalls, heavy random stalls, and a fixed pattern.
    // A hold asked by a test keeps it stalled for a long stretch.
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            case ((cycle_count / 400) % 4)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= ($urandom_range(0, 9) < 7);
                default: result_stall <= ((cycle_count % 11) < 6);
            endcase
        end
    end

    // Every accepted result must match the oldest prediction.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no request pending: %p", result);
                failures++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result.event_valid !== want.event_valid)
                begin
                    $error("event_valid mismatch: expected %0d, got %0d",
                           want.event_valid, result.event_valid);
                    failures++;
                end
                if (result.event_kind !== want.event_kind)
                begin
                    $error("event_kind mismatch: expected %0d, got %0d",
                           want.event_kind, result.event_kind);
                    failures++;
                end
                if (result.event_char !== want.event_char)
                begin
                    $error("event_char mismatch: expected 0x%02h, got 0x%02h",
                           want.event_char, result.event_char);
                    failures++;
                end
                if (result.keyboard_present !== want.keyboard_present)
                begin
                    $error("keyboard_present mismatch: expected %0d, got %0d",
                           want.keyboard_present, result.keyboard_present);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Connected flag through attach and detach, and polls of an empty ring.
    task automatic test_link_state();
        send_request(plain_request(MODE_POLL));
        send_request(plain_request(MODE_ATTACH));
        send_request(plain_request(MODE_POLL));
        send_request(plain_request(MODE_DETACH));
        send_request(plain_request(MODE_POLL));
    endtask

    // Every key mapping, both shift bits, held keys, a code repeated within
    // one report, unmapped codes, and new presses again after a detach.
    task automatic test_key_decoding();
        send_request(make_request(MODE_REPORT, 8'h00, 8'h04, 8'h1D, 8'h1E, 8'h27, 8'h28, 8'h29));
        // Right shift turns tab into shift-tab.
        send_request(make_request(MODE_REPORT, 8'h20, 8'h2A, 8'h52, 8'h51, 8'h50, 8'h4F, 8'h2B));
        // Left shift: capitals and digit symbols.
        send_request(make_request(MODE_REPORT, 8'h02, 8'h04, 8'h1D, 8'h1E, 8'h26, 8'h27, 8'h2D));
        // Minus is still held here; keypad add without shift is silent.
        send_request(make_request(MODE_REPORT, 8'h00, 8'h2E, 8'h2D, 8'h37, 8'h63, 8'h55, 8'h57));
        send_request(make_request(MODE_REPORT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // All modifier bits set, the same new code twice, and unmapped codes.
        send_request(make_request(MODE_REPORT, 8'hFF, 8'h57, 8'h57, 8'h2E, 8'hFF, 8'h01, 8'h58));
        send_request(plain_request(MODE_DETACH));
        // The same keys count as new after a detach; plain tab this time.
        send_request(make_request(MODE_REPORT, 8'h00, 8'h57, 8'h57, 8'h2E, 8'h2B, 8'h01, 8'h58));
        poll_until_empty();
    endtask

    // Fills the ring, offers more presses that must be dropped, then drains.
    task automatic test_queue_overflow();
        int extra;
        extra = 0;
        while (extra < 3)
        begin
            if (queued_keys.size() == EVENT_ROOM)
            begin
                extra++;
            end
            send_request(make_request(MODE_REPORT, 8'($urandom),
                8'($urandom_range(8'h04, 8'h27)), 8'($urandom_range(8'h04, 8'h27)),
                8'($urandom_range(8'h04, 8'h27)), 8'($urandom_range(8'h04, 8'h27)),
                8'($urandom_range(8'h04, 8'h27)), 8'($urandom_range(8'h04, 8'h27))));
            // Release everything so the next report presses fresh keys.
            send_request(make_request(MODE_REPORT, 8'h00, 8'h00, 8'h00, 8'h00,
                                      8'h00, 8'h00, 8'h00));
        end
        poll_until_empty();
    endtask

    // The receiver holds off for a long stretch while requests keep coming
    // back to back, so the block backs up and stalls its input.
    task automatic test_stall_pressure();
        pace_on = 1'b0;
        hold_requests++;
        repeat (12)
        begin
            send_request(typing_report());
            send_request(plain_request(MODE_POLL));
        end
        pace_on = 1'b1;
    endtask

    // Mostly typing-like reports and polls; phases alternate between
    // filling the ring and draining it. Some noise reports, attaches and
    // detaches are mixed in.
    task automatic test_random_traffic();
        int  pick;
        bit  filling;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            filling = ((n / 50) % 2) == 0;
            pick    = $urandom_range(0, 99);
            if (pick < 3)
            begin
                send_request(plain_request(MODE_ATTACH));
            end
            else if (pick < 6)
            begin
                send_request(plain_request(MODE_DETACH));
            end
            else if (pick < 12)
            begin
                send_request(make_request(MODE_REPORT, 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom)));
            end
            else if (pick < (filling ? 75 : 35))
            begin
                send_request(typing_report());
            end
            else
            begin
                send_request(plain_request(MODE_POLL));
            end
        end
    endtask

    initial
    begin
        link_up   = 1'b0;
        held_keys = '{default: '0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_link_state();
        test_key_decoding();
        test_queue_overflow();
        test_stall_pressure();
        test_random_traffic();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("tb_hid_keyboard_event_queue_top passed");
        end
        else
        begin
            $display("tb_hid_keyboard_event_queue_top failed");
        end
        $finish;
    end

endmodule
